// File: src/wia_pkg.sv
// ----------------------------------------------------------------------------
// wia_pkg
// Types and operation codes shared by the wide integer ALU modules.
// ----------------------------------------------------------------------------
package wia_pkg;

   localparam int OP_BITS   = 5;
   localparam int HALF_BITS = 64;

   localparam logic [OP_BITS-1:0] OP_ADD  = 5'd0;
   localparam logic [OP_BITS-1:0] OP_SUB  = 5'd1;
   localparam logic [OP_BITS-1:0] OP_MUL  = 5'd2;
   localparam logic [OP_BITS-1:0] OP_UDIV = 5'd3;
   localparam logic [OP_BITS-1:0] OP_UMOD = 5'd4;
   localparam logic [OP_BITS-1:0] OP_SDIV = 5'd5;
   localparam logic [OP_BITS-1:0] OP_SMOD = 5'd6;
   localparam logic [OP_BITS-1:0] OP_SHL  = 5'd7;
   localparam logic [OP_BITS-1:0] OP_SHR  = 5'd8;
   localparam logic [OP_BITS-1:0] OP_SAR  = 5'd9;
   localparam logic [OP_BITS-1:0] OP_AND  = 5'd10;
   localparam logic [OP_BITS-1:0] OP_OR   = 5'd11;
   localparam logic [OP_BITS-1:0] OP_XOR  = 5'd12;
   localparam logic [OP_BITS-1:0] OP_NOT  = 5'd13;
   localparam logic [OP_BITS-1:0] OP_NEG  = 5'd14;
   localparam logic [OP_BITS-1:0] OP_UCMP = 5'd15;
   localparam logic [OP_BITS-1:0] OP_SCMP = 5'd16;

   localparam logic [1:0] CMP_LESS    = 2'd0;
   localparam logic [1:0] CMP_EQUAL   = 2'd1;
   localparam logic [1:0] CMP_GREATER = 2'd2;

   typedef struct packed {
      logic [OP_BITS-1:0]   op;
      logic [HALF_BITS-1:0] operand_a_high;
      logic [HALF_BITS-1:0] operand_a_low;
      logic [HALF_BITS-1:0] operand_b_high;
      logic [HALF_BITS-1:0] operand_b_low;
   } req_type;

   typedef struct packed {
      logic [HALF_BITS-1:0] result_high;
      logic [HALF_BITS-1:0] result_low;
      logic [1:0]           compare_code;
      logic                 error_flag;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;     // capture operands on an accepted beat
      logic step;     // one multiply or divide iteration
      logic finish;   // form the result register
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic iterative;  // loaded op needs the bit loop
   } sts_type;

endpackage

// File: src/wia_datapath.sv
// ----------------------------------------------------------------------------
// wia_datapath
// Operand registers, shift-add multiplier, restoring divider and result mux.
// ----------------------------------------------------------------------------
module wia_datapath
   import wia_pkg::*;
#(
   parameter int WORD_BITS = 128
) (
   input  logic    clock,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp
);

   localparam int W = WORD_BITS;

   logic [OP_BITS-1:0] op_ff, op_in;
   logic [W-1:0] a_ff, a_in;   // multiplicand / dividend shifting out
   logic [W-1:0] b_ff, b_in;   // multiplier / divisor magnitude
   logic [W-1:0] acc_ff, acc_in;  // product or quotient
   logic [W-1:0] rem_ff, rem_in;
   logic         neg_q_ff, neg_q_in, neg_r_ff, neg_r_in, zero_ff, zero_in;
   logic [W-1:0] ra_ff, ra_in, rb_ff, rb_in;   // raw operands
   rsp_type      rsp_ff, rsp_in;

   logic [W-1:0] a_raw, b_raw, a_mag, b_mag, sh_res, res, trial_rem;
   logic [W:0]   diff;
   logic [HALF_BITS-1:0] amt;
   logic         is_sdiv, big_shift;
   logic [1:0]   cmp;

   assign a_raw = W'({req.operand_a_high, req.operand_a_low});
   assign b_raw = W'({req.operand_b_high, req.operand_b_low});
   assign is_sdiv = (req.op == OP_SDIV) || (req.op == OP_SMOD);
   assign a_mag = (is_sdiv && a_raw[W-1]) ? -a_raw : a_raw;
   assign b_mag = (is_sdiv && b_raw[W-1]) ? -b_raw : b_raw;

   assign sts.iterative = (op_ff == OP_MUL) || (op_ff == OP_UDIV) ||
                          (op_ff == OP_UMOD) || (op_ff == OP_SDIV) || (op_ff == OP_SMOD);

   // Restoring divide: shift the next dividend bit into the remainder.
   assign trial_rem = {rem_ff[W-2:0], a_ff[W-1]};
   assign diff = {1'b0, trial_rem} - {1'b0, b_ff};

   always_comb begin
      op_in = op_ff; a_in = a_ff; b_in = b_ff; acc_in = acc_ff; rem_in = rem_ff;
      neg_q_in = neg_q_ff; neg_r_in = neg_r_ff; zero_in = zero_ff;
      ra_in = ra_ff; rb_in = rb_ff;
      if (cmd.load) begin
         op_in = req.op;
         ra_in = a_raw;
         rb_in = b_raw;
         a_in = a_mag;
         b_in = b_mag;
         acc_in = '0;
         rem_in = '0;
         zero_in = (b_raw == '0);
         neg_q_in = is_sdiv && (a_raw[W-1] != b_raw[W-1]);
         neg_r_in = is_sdiv && a_raw[W-1];
      end else if (cmd.step) begin
         if (op_ff == OP_MUL) begin
            if (b_ff[0]) acc_in = acc_ff + a_ff;
            a_in = {a_ff[W-2:0], 1'b0};
            b_in = {1'b0, b_ff[W-1:1]};
         end else begin
            a_in = {a_ff[W-2:0], 1'b0};
            if (!diff[W]) begin
               rem_in = diff[W-1:0];
               acc_in = {acc_ff[W-2:0], 1'b1};
            end else begin
               rem_in = trial_rem;
               acc_in = {acc_ff[W-2:0], 1'b0};
            end
         end
      end
   end

   // Non-iterative operations work from the raw operand registers.
   assign amt = rb_ff[HALF_BITS-1:0];
   assign big_shift = (amt >= HALF_BITS'(W));
   always_comb begin
      sh_res = '0;
      case (op_ff)
         OP_SHL: sh_res = big_shift ? '0 : ra_ff << amt[$clog2(W)-1:0];
         OP_SHR: sh_res = big_shift ? '0 : ra_ff >> amt[$clog2(W)-1:0];
         default: sh_res = big_shift ? {W{ra_ff[W-1]}} :
                           W'($signed(ra_ff) >>> amt[$clog2(W)-1:0]);
      endcase
   end

   always_comb begin
      cmp = CMP_EQUAL;
      if (op_ff == OP_UCMP || op_ff == OP_SCMP) begin
         if (ra_ff == rb_ff) cmp = CMP_EQUAL;
         else if ((op_ff == OP_SCMP) && (ra_ff[W-1] != rb_ff[W-1]))
            cmp = ra_ff[W-1] ? CMP_LESS : CMP_GREATER;
         else cmp = (ra_ff < rb_ff) ? CMP_LESS : CMP_GREATER;
      end
   end

   always_comb begin
      res = '0;
      case (op_ff) inside
         OP_ADD:  res = ra_ff + rb_ff;
         OP_SUB:  res = ra_ff - rb_ff;
         OP_MUL:  res = acc_ff;
         OP_UDIV: res = zero_ff ? '0 : acc_ff;
         OP_UMOD: res = zero_ff ? '0 : rem_ff;
         OP_SDIV: res = zero_ff ? '0 : (neg_q_ff ? -acc_ff : acc_ff);
         OP_SMOD: res = zero_ff ? '0 : (neg_r_ff ? -rem_ff : rem_ff);
         OP_SHL, OP_SHR, OP_SAR: res = sh_res;
         OP_AND:  res = ra_ff & rb_ff;
         OP_OR:   res = ra_ff | rb_ff;
         OP_XOR:  res = ra_ff ^ rb_ff;
         OP_NOT:  res = ~ra_ff;
         OP_NEG:  res = -ra_ff;
         default: res = '0;
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.finish) begin
         {rsp_in.result_high, rsp_in.result_low} = (2*HALF_BITS)'(res);
         rsp_in.compare_code = cmp;
         rsp_in.error_flag = zero_ff && ((op_ff == OP_UDIV) || (op_ff == OP_UMOD) ||
                                         (op_ff == OP_SDIV) || (op_ff == OP_SMOD));
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; a_ff <= a_in; b_ff <= b_in; acc_ff <= acc_in; rem_ff <= rem_in;
      neg_q_ff <= neg_q_in; neg_r_ff <= neg_r_in; zero_ff <= zero_in;
      ra_ff <= ra_in; rb_ff <= rb_in; rsp_ff <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

// File: src/wia_control.sv
// ----------------------------------------------------------------------------
// wia_control
// Sequencer: load, iterate over the word for multiply and divide, finish.
// ----------------------------------------------------------------------------
module wia_control
   import wia_pkg::*;
#(
   parameter int WORD_BITS = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam int CNT_BITS = $clog2(WORD_BITS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DECODE = 2'd1;
   localparam logic [1:0] ST_LOOP = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                valid_ff, valid_in;

   // A held result does not block the next beat until it would be overwritten.
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      valid_in = valid_ff && !rsp_ready;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cnt_in = CNT_BITS'(WORD_BITS);
            state_in = sts.iterative ? ST_LOOP : ST_DONE;
         end
         ST_LOOP: begin
            cmd.step = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_loop_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOP) |-> (cnt_ff != '0))
      else $error("loop entered with zero count");
   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.finish}))
      else $error("conflicting datapath commands");
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finished result not presented");
`endif

endmodule

// File: src/wide_integer_alu_128_core.sv
// Multiply and divide run one bit per cycle through the shared iteration unit;
// one item is in work at a time.
// The next beat is accepted in the cycle after a result forms.
// A finished result waits in the output register while the next beat is loaded.
// Synchronous active-high reset clears the sequencer and the result valid.
// ----------------------------------------------------------------------------
// wide_integer_alu_128_core
// 128-bit integer ALU with bit-serial multiply and restoring divide.
// ----------------------------------------------------------------------------
module wide_integer_alu_128_core
   import wia_pkg::*;
#(
   parameter int WORD_BITS = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   wia_control #(.WORD_BITS(WORD_BITS)) u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .sts(sts), .cmd(cmd)
   );

   wia_datapath #(.WORD_BITS(WORD_BITS)) u_datapath (
      .clock(clock), .req(req_data), .cmd(cmd), .sts(sts), .rsp(rsp_data)
   );

endmodule

// File: sim/wide_integer_alu_128_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wide_integer_alu_128_core_tb
// Drives directed and random operations into the 128-bit ALU, computes the
// expected result, compare code and error flag for each accepted beat,
// and checks every result beat against them in order.
// ----------------------------------------------------------------------------
module wide_integer_alu_128_core_tb;
   import wia_pkg::*;

   class alu_scoreboard;
      rsp_type pending_results[$];
      int      error_count;

      function new();
         error_count = 0;
      endfunction

      // Unsigned restoring division, 128 bits. The remainder is kept to 128
      // bits, so its top bit falls off when it is shifted.
      function void udivmod(input logic [127:0] n, input logic [127:0] d,
                            output logic [127:0] q, output logic [127:0] r);
         logic [128:0] rem;
         q = '0;
         rem = '0;
         for (int i = 127; i >= 0; i--) begin
            rem = {1'b0, rem[126:0], n[i]};
            if (rem >= {1'b0, d}) begin
               rem = rem - {1'b0, d};
               q[i] = 1'b1;
            end
         end
         r = rem[127:0];
      endfunction

      function rsp_type compute(input req_type item);
         rsp_type       res;
         logic [127:0]  a, b, v, q, r, ua, ub;
         logic [255:0]  prod;
         logic [63:0]   amt;
         a = {item.operand_a_high, item.operand_a_low};
         b = {item.operand_b_high, item.operand_b_low};
         amt = item.operand_b_low;
         v = '0;
         res.compare_code = CMP_EQUAL;
         res.error_flag = 1'b0;
         case (item.op) inside
            OP_ADD: v = a + b;
            OP_SUB: v = a - b;
            OP_MUL: begin
               prod = a * b;
               v = prod[127:0];
            end
            OP_UDIV, OP_UMOD: begin
               if (b == '0) res.error_flag = 1'b1;
               else begin
                  udivmod(a, b, q, r);
                  v = (item.op == OP_UDIV) ? q : r;
               end
            end
            OP_SDIV, OP_SMOD: begin
               if (b == '0) res.error_flag = 1'b1;
               else begin
                  ua = a[127] ? -a : a;
                  ub = b[127] ? -b : b;
                  udivmod(ua, ub, q, r);
                  if (item.op == OP_SDIV) v = (a[127] != b[127]) ? -q : q;
                  else v = a[127] ? -r : r;
               end
            end
            OP_SHL: v = (amt >= 128) ? '0 : a << amt[6:0];
            OP_SHR: v = (amt >= 128) ? '0 : a >> amt[6:0];
            OP_SAR: begin
               if (amt >= 128) v = {128{a[127]}};
               else v = $signed(a) >>> amt[6:0];
            end
            OP_AND: v = a & b;
            OP_OR:  v = a | b;
            OP_XOR: v = a ^ b;
            OP_NOT: v = ~a;
            OP_NEG: v = -a;
            OP_UCMP: res.compare_code = (a < b) ? CMP_LESS :
                                        (a == b) ? CMP_EQUAL : CMP_GREATER;
            OP_SCMP: res.compare_code = ($signed(a) < $signed(b)) ? CMP_LESS :
                                        (a == b) ? CMP_EQUAL : CMP_GREATER;
            default: ;
         endcase
         res.result_high = v[127:64];
         res.result_low = v[63:0];
         return res;
      endfunction

      function void note_request(input req_type item);
         pending_results.insert(pending_results.size(), compute(item));
      endfunction

      function void check_result(input rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, got);
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         if (got.result_high !== want.result_high) begin
            $display("%0t: result_high expected %h actual %h", $time,
                     want.result_high, got.result_high);
            error_count++;
         end
         if (got.result_low !== want.result_low) begin
            $display("%0t: result_low expected %h actual %h", $time,
                     want.result_low, got.result_low);
            error_count++;
         end
         if (got.compare_code !== want.compare_code) begin
            $display("%0t: compare_code expected %0d actual %0d", $time,
                     want.compare_code, got.compare_code);
            error_count++;
         end
         if (got.error_flag !== want.error_flag) begin
            $display("%0t: error_flag expected %0d actual %0d", $time,
                     want.error_flag, got.error_flag);
            error_count++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   alu_scoreboard alu_board;
   int  idle_pct;
   int  hold_cycles;
   bit  stimulus_done;

   wide_integer_alu_128_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #80ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Monitor: note accepted requests and check results at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) alu_board.note_request(req_data);
         if (rsp_valid && rsp_ready) alu_board.check_result(rsp_data);
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] pick_half();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3: return 64'h7fff_ffff_ffff_ffff;
         4: return 64'd1;
         5: return 64'(longint'(-$signed({1'b0, $urandom_range(3)})));
         default: return rand64();
      endcase
   endfunction

   // Valid stays high after the handshake edge; an idle cycle in the next call
   // or drain() lowers it at the following falling edge.
   task automatic send_beat(input req_type item);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_op(input logic [OP_BITS-1:0] op, input logic [63:0] ah,
                          input logic [63:0] al, input logic [63:0] bh,
                          input logic [63:0] bl);
      req_type item;
      item.op = op;
      item.operand_a_high = ah;
      item.operand_a_low = al;
      item.operand_b_high = bh;
      item.operand_b_low = bl;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      send_beat(item);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (alu_board.pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic send_random(input int count);
      logic [OP_BITS-1:0] op;
      logic [63:0] bh, bl;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(19) == 0) ? OP_BITS'($urandom_range(31))
                                        : OP_BITS'($urandom_range(16));
         bh = pick_half();
         bl = pick_half();
         if ((op == OP_SHL || op == OP_SHR || op == OP_SAR)
             && $urandom_range(3) != 0)
            bl = 64'($urandom_range(140));
         else if ((op >= OP_UDIV && op <= OP_SMOD) && $urandom_range(2) == 0) begin
            bh = (op[0]) ? '0 : '1;
            bl = rand64() >> $urandom_range(63);
         end
         send_op(op, pick_half(), pick_half(), bh, bl);
      end
   endtask

   initial begin
      logic [63:0] mn;
      alu_board = new();
      idle_pct = 26;
      hold_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      mn = 64'h8000_0000_0000_0000;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: each operation with edge operands.
      send_op(OP_ADD, '1, '1, 64'd0, 64'd1);
      send_op(OP_SUB, 64'd0, 64'd0, 64'd0, 64'd1);
      send_op(OP_MUL, '1, '1, '1, '1);
      send_op(OP_MUL, 64'd1, 64'd3, 64'd0, 64'h1_0000_0001);
      send_op(OP_UDIV, '1, '1, 64'd0, 64'd7);
      send_op(OP_UMOD, '1, '1, 64'd0, 64'd7);
      send_op(OP_UDIV, 64'd5, 64'd5, 64'd0, 64'd0);
      send_op(OP_SMOD, 64'd5, 64'd5, 64'd0, 64'd0);
      send_op(OP_SDIV, mn, 64'd0, '1, '1);
      send_op(OP_SMOD, mn, 64'd0, '1, '1);
      send_op(OP_SDIV, '1, 64'hffff_ffff_ffff_fff9, 64'd0, 64'd2);
      send_op(OP_SMOD, '1, 64'hffff_ffff_ffff_fff9, 64'd0, 64'd2);
      send_op(OP_SHL, '1, '1, '1, 64'd0);
      send_op(OP_SHL, 64'd3, '1, 64'd0, 64'd5);
      send_op(OP_SHR, '1, '1, 64'd0, 64'd127);
      send_op(OP_SHR, '1, '1, 64'd0, 64'd128);
      send_op(OP_SAR, mn, 64'd0, 64'd0, 64'd70);
      send_op(OP_SAR, mn, 64'd0, 64'd0, '1);
      send_op(OP_AND, '1, 64'd12, 64'd10, 64'd10);
      send_op(OP_OR, 64'd1, 64'd2, 64'd4, 64'd8);
      send_op(OP_XOR, '1, '1, 64'd5, 64'd5);
      send_op(OP_NOT, 64'd0, '1, '1, '1);
      send_op(OP_NEG, mn, 64'd0, 64'd0, 64'd0);
      send_op(OP_UCMP, mn, 64'd0, 64'd1, 64'd0);
      send_op(OP_SCMP, mn, 64'd0, 64'd1, 64'd0);
      send_op(OP_SCMP, 64'd2, 64'd2, 64'd2, 64'd2);
      send_op(5'd31, '1, '1, '1, '1);

      // Pause until everything has come back.
      drain();

      // Long receiver hold-off while short operations keep arriving.
      hold_cycles = 400;
      idle_pct = 0;
      for (int i = 0; i < 20; i++)
         send_op(OP_XOR, rand64(), rand64(), rand64(), rand64());
      send_random(200);

      // Stretch with no idling on either side.
      send_random(150);
      idle_pct = 26;
      send_random(430);

      drain();
      repeat (300) @(negedge clock);
      if (alu_board.error_count == 0 && alu_board.pending_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
